@@ design/apcd_pkg.sv @@
// ============================================================================
// apcd_pkg: shared types and constants of the coherent ASK/PSK demodulator
// Holds the register map, the configuration record, the carrier sine table
// and the stage record handed from the carrier stage to the integrator.
// ============================================================================
package apcd_pkg;

   // Carrier table and bit period sizing.
   localparam int SINE_ENTRIES   = 256;
   localparam int SINE_BITS      = $clog2(SINE_ENTRIES);
   localparam int MAX_BIT_LENGTH = 1024;
   localparam int CNT_W          = $clog2(MAX_BIT_LENGTH);

   // Field widths.
   localparam int SAMPLE_W  = 16;
   localparam int LEN_W     = 11;
   localparam int PHASE_W   = 32;
   localparam int SUM_W     = 32;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;
   localparam int TRIM_W    = 2 * SAMPLE_W - 15;

   // Reset values of the registers.
   localparam logic [LEN_W-1:0]          BIT_LENGTH_RST     = 11'd288;
   localparam logic [PHASE_W-1:0]        PHASE_STEP_RST     = 32'd238609294;
   localparam logic signed [SUM_W-1:0]   DECISION_LEVEL_RST = 32'sd3538944;

   localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE_PSK       = 4'd0,
      CSR_BIT_LENGTH     = 4'd1,
      CSR_PHASE_STEP     = 4'd2,
      CSR_DECISION_LEVEL = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic                      mode_psk;
      logic [LEN_W-1:0]          bit_length;
      logic [PHASE_W-1:0]        phase_step;
      logic signed [SUM_W-1:0]   decision_level;
   } apcd_cfg_type;

   // One sample paired with its carrier value, on its way to the multiplier.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] carrier;
      logic                       last;
   } apcd_item_type;

   typedef logic [SINE_ENTRIES-1:0][SAMPLE_W-1:0] sine_table_type;

   // Quarter-wave sine of a Q28 angle by the odd Taylor series up to the
   // ninth power, rounded to Q15 and clamped.
   function automatic logic [SAMPLE_W-1:0] quarter_sine(logic [63:0] theta);
      logic [63:0] term;
      logic [63:0] acc;
      term = theta;
      acc  = theta;
      term = (term * theta) >> 28;
      term = (term * theta) >> 28;
      term = term / 64'd6;
      acc  = acc - term;
      term = (term * theta) >> 28;
      term = (term * theta) >> 28;
      term = term / 64'd20;
      acc  = acc + term;
      term = (term * theta) >> 28;
      term = (term * theta) >> 28;
      term = term / 64'd42;
      acc  = acc - term;
      term = (term * theta) >> 28;
      term = (term * theta) >> 28;
      term = term / 64'd72;
      acc  = acc + term;
      acc  = (acc + 64'd4096) >> 13;
      if (acc > 64'd32767) begin
         acc = 64'd32767;
      end
      return acc[SAMPLE_W-1:0];
   endfunction

   // Full-wave table built from quarter-wave symmetry at elaboration.
   function automatic sine_table_type build_sine();
      sine_table_type             tbl;
      logic [63:0]                u;
      logic [63:0]                quad;
      logic [63:0]                rem;
      logic [63:0]                m;
      logic signed [SAMPLE_W-1:0] v;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         u    = 64'(4 * k);
         quad = u / SINE_ENTRIES;
         rem  = u % SINE_ENTRIES;
         m    = quad[0] ? (64'(SINE_ENTRIES) - rem) : rem;
         v    = signed'(quarter_sine((HALF_PI_Q28 * m) / SINE_ENTRIES));
         tbl[k] = (quad >= 64'd2) ? -v : v;
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine();

endpackage

@@ design/apcd_csr.sv @@
// ============================================================================
// apcd_csr: configuration registers
// Four writable registers, always ready; unknown indexes are ignored.
// ============================================================================
module apcd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [apcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [apcd_pkg::CSR_DAT_W-1:0] csr_data,
   output apcd_pkg::apcd_cfg_type         cfg
);
   import apcd_pkg::*;

   apcd_cfg_type cfg_ff;
   apcd_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MODE_PSK:       cfg_in.mode_psk       = csr_data[0];
            CSR_BIT_LENGTH:     cfg_in.bit_length     = csr_data[LEN_W-1:0];
            CSR_PHASE_STEP:     cfg_in.phase_step     = csr_data[PHASE_W-1:0];
            CSR_DECISION_LEVEL: cfg_in.decision_level = signed'(csr_data[SUM_W-1:0]);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_psk       <= 1'b0;
         cfg_ff.bit_length     <= BIT_LENGTH_RST;
         cfg_ff.phase_step     <= PHASE_STEP_RST;
         cfg_ff.decision_level <= DECISION_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

@@ design/apcd_dump.sv @@
// ============================================================================
// apcd_dump: multiply, integrate and dump
// Product stage, saturating accumulator with bit counter, and result register.
// ============================================================================
module apcd_dump (
   input  logic                               clock,
   input  logic                               reset,
   input  apcd_pkg::apcd_cfg_type             cfg,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  apcd_pkg::apcd_item_type            in_item,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_bit_out,
   output logic signed [apcd_pkg::SUM_W-1:0]  rsp_bit_sum
);
   import apcd_pkg::*;

   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   logic signed [TRIM_W-1:0]   s2_trim_ff;
   logic                       s2_last_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [SUM_W-1:0]    rsp_sum_ff;

   logic signed [2*SAMPLE_W-1:0] prod;
   logic signed [SUM_W:0]        acc;
   logic signed [SUM_W-1:0]      sat;
   logic [CNT_W:0]               count;
   logic [31:0]                  len_raw;
   logic [31:0]                  len_eff;
   logic                         fire;
   logic                         out_free;
   logic                         s2_go;
   logic                         s2_load;

   // The product is Q2.30; dropping 15 bits is a floor, matching the trim.
   assign prod = in_item.sample * in_item.carrier;

   always_comb begin
      acc = SUM_W'(0) + (SUM_W+1)'(sum_ff) + (SUM_W+1)'(s2_trim_ff);
      if (acc[SUM_W] != acc[SUM_W-1]) begin
         sat = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sat = acc[SUM_W-1:0];
      end
   end

   always_comb begin
      len_raw = 32'(cfg.bit_length);
      if (len_raw == 32'd0) begin
         len_eff = 32'd1;
      end else if (len_raw > 32'(MAX_BIT_LENGTH)) begin
         len_eff = 32'(MAX_BIT_LENGTH);
      end else begin
         len_eff = len_raw;
      end
      count = (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(1);
      fire  = (32'(count) >= len_eff) || s2_last_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_go    = s2_valid_ff && (!fire || out_free);
   assign in_ready = !s2_valid_ff || s2_go;
   assign s2_load  = in_valid && in_ready;

   always_comb begin
      s2_valid_in  = s2_load ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s2_go) begin
         if (fire) begin
            cnt_in       = '0;
            sum_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            cnt_in = count[CNT_W-1:0];
            sum_in = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_trim_ff <= prod[2*SAMPLE_W-1:15];
         s2_last_ff <= in_item.last;
      end
      if (s2_go && fire) begin
         rsp_sum_ff <= sat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bit_sum = rsp_sum_ff;
   // The user must change configuration only while idle; the block does not enforce it.
   assign rsp_bit_out = rsp_sum_ff > cfg.decision_level;

`ifndef ASSERT_OFF
   a_dump_clears: assert property (@(posedge clock) disable iff (reset)
      s2_go && fire |=> cnt_ff == '0 && sum_ff == '0)
      else $error("integrator not cleared after a decision");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      s2_go && !fire |=> cnt_ff == CNT_W'($past(cnt_ff) + 1'b1))
      else $error("bit counter did not advance by one");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !(s2_go && fire))
      else $error("pending result overwritten");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_go |=> s2_valid_ff && $stable(s2_trim_ff))
      else $error("stalled product stage lost its contents");
`endif

endmodule

@@ design/ask_psk_coherent_demodulator_top.sv @@
// ============================================================================
// ask_psk_coherent_demodulator_top: coherent ASK/BPSK integrate-and-dump
// Mixes received samples with a table-driven carrier, integrates over a bit
// period and decides one bit per period or at the end of a stream.
// ============================================================================
// Usage:
//   Requests arrive on the req_ channel (valid/ready), one signed Q1.15
//   sample each, with req_stream_end marking the last sample of a stream.
//   A decision appears on the rsp_ channel (valid/ready) once per bit period
//   of bit_length samples (zero acts as one, above 1024 as 1024), or at the
//   stream end sample for a partial bit; other requests produce no response.
//   Throughput is one request per cycle unless backpressure holds it. A
//   response becomes valid once the request closing its bit has passed the
//   carrier lookup register, the product register and then the result register.
//   When the receiver stalls, the result register holds its response while
//   requests that only add to the sum keep flowing; a request that closes a
//   bit waits in the product stage, and backpressure then reaches req_ready.
//   Configuration is written on the csr_ port, always ready; the user must
//   write it only while no request is in flight, which the block does not
//   enforce. Synchronous reset restores the register defaults and clears
//   the carrier phase, bit counter, running sum and all valids.
// ============================================================================
module ask_psk_coherent_demodulator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [apcd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_stream_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_bit_out,
   output logic signed [apcd_pkg::SUM_W-1:0]     rsp_bit_sum,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [apcd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [apcd_pkg::CSR_DAT_W-1:0]        csr_data
);
   import apcd_pkg::*;

   apcd_cfg_type                cfg;
   logic [PHASE_W-1:0]          phase_ff;
   logic [PHASE_W-1:0]          phase_in;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   apcd_item_type               s1_item_ff;
   apcd_item_type               s1_item_in;
   logic                        dump_ready;
   logic                        req_take;
   logic                        s1_go;
   logic [SINE_BITS-1:0]        sine_idx;
   logic signed [SAMPLE_W-1:0]  sine_val;

   apcd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The table index is the top bits of the phase accumulator, taken before
   // the phase advances.
   assign sine_idx = phase_ff[PHASE_W-1 -: SINE_BITS];
   assign sine_val = signed'(SINE_TABLE[sine_idx]);

   assign s1_go     = s1_valid_ff && dump_ready;
   assign req_ready = !s1_valid_ff || dump_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_item_in.sample  = req_sample;
      // PSK mode uses the carrier shifted by pi, which is its negation.
      s1_item_in.carrier = cfg.mode_psk ? -sine_val : sine_val;
      s1_item_in.last    = req_stream_end;
      s1_valid_in        = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      phase_in           = phase_ff;
      if (req_take) begin
         // A stream end restarts the carrier at phase zero for the next stream.
         phase_in = req_stream_end ? '0 : phase_ff + cfg.phase_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= s1_item_in;
      end
   end

   apcd_dump u_dump (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (s1_valid_ff),
      .in_ready    (dump_ready),
      .in_item     (s1_item_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_bit_out (rsp_bit_out),
      .rsp_bit_sum (rsp_bit_sum)
   );

`ifndef ASSERT_OFF
   a_phase_restart: assert property (@(posedge clock) disable iff (reset)
      req_take && req_stream_end |=> phase_ff == '0)
      else $error("carrier phase not restarted at stream end");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(phase_ff))
      else $error("carrier phase moved without a request");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !dump_ready |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stalled carrier stage lost its contents");
`endif

endmodule

@@ tb/apcd_decision_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// apcd_decision_checker: bit decision predictor and response scoreboard
// Watches the request, response and register ports of the demodulator,
// mixes each accepted sample with its own carrier table, integrates and
// queues the decisions it expects, then compares every response with them.
// ============================================================================
module apcd_decision_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [apcd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_stream_end,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_bit_out,
   input  logic signed [apcd_pkg::SUM_W-1:0]    rsp_bit_sum,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [apcd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [apcd_pkg::CSR_DAT_W-1:0]       csr_data,
   output int                                   mismatch_count,
   output int                                   pending_decisions,
   output int                                   samples_seen,
   output int                                   decisions_checked
);
   import apcd_pkg::*;

   localparam longint SUM_TOP    = 64'sd2147483647;
   localparam longint SUM_BOTTOM = -64'sd2147483648;

   typedef struct packed {
      logic                    bit_out;
      logic signed [SUM_W-1:0] bit_sum;
   } decision_type;

   decision_type               expected_decisions[$];
   apcd_cfg_type               regs;
   logic [PHASE_W-1:0]         lo_phase;
   int unsigned                samples_in_bit;
   logic signed [SUM_W-1:0]    integrator;
   logic signed [SAMPLE_W-1:0] carrier_rom [SINE_ENTRIES];
   int                         errors;
   int                         n_samples;
   int                         n_checked;

   // Odd Taylor terms up to the ninth power of a Q28 angle, rounded to Q15.
   function automatic longint unsigned taylor_sine_q15(longint unsigned ang);
      longint unsigned t;
      longint unsigned s;
      t = ang;
      s = ang;
      for (int n = 1; n <= 4; n++) begin
         t = (t * ang) >> 28;
         t = (t * ang) >> 28;
         t = t / (64'(2 * n) * 64'(2 * n + 1));
         if (n % 2 == 1) begin
            s = s - t;
         end else begin
            s = s + t;
         end
      end
      s = (s + 64'd4096) >> 13;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s;
   endfunction

   initial begin : fill_rom
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned m;
      longint unsigned v;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         quad = (4 * k) / SINE_ENTRIES;
         rem  = (4 * k) % SINE_ENTRIES;
         m    = quad[0] ? SINE_ENTRIES - rem : rem;
         v    = taylor_sine_q15((HALF_PI_Q28 * m) / SINE_ENTRIES);
         carrier_rom[k] = (quad >= 2) ? -16'(v) : 16'(v);
      end
   end

   task automatic restore_defaults();
      regs.mode_psk       = 1'b0;
      regs.bit_length     = BIT_LENGTH_RST;
      regs.phase_step     = PHASE_STEP_RST;
      regs.decision_level = DECISION_LEVEL_RST;
      lo_phase            = '0;
      samples_in_bit      = 0;
      integrator          = '0;
      expected_decisions.delete();
   endtask

   task automatic apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] d);
      case (idx)
         CSR_MODE_PSK:       regs.mode_psk = d[0];
         CSR_BIT_LENGTH:     regs.bit_length = d[LEN_W-1:0];
         CSR_PHASE_STEP:     regs.phase_step = d;
         CSR_DECISION_LEVEL: regs.decision_level = signed'(d);
         default: ;
      endcase
   endtask

   // One sample through mixer and integrator; queues a decision when due.
   task automatic mix_and_integrate(logic signed [SAMPLE_W-1:0] s, logic last);
      longint unsigned         rom_addr;
      logic signed [SAMPLE_W-1:0] lo;
      longint                  product;
      longint                  total;
      int unsigned             span;
      int unsigned             count;
      decision_type            d;
      rom_addr = ({32'd0, lo_phase} * 64'(SINE_ENTRIES)) >> 32;
      if (rom_addr >= SINE_ENTRIES) begin
         rom_addr = SINE_ENTRIES - 1;
      end
      lo = carrier_rom[int'(rom_addr)];
      if (regs.mode_psk) begin
         lo = -lo;
      end
      lo_phase = lo_phase + regs.phase_step;

      // Floor of the Q2.30 product scaled back to Q2.15.
      product = (longint'(s) * longint'(lo)) >>> 15;
      total   = longint'(integrator) + product;
      if (total > SUM_TOP) begin
         total = SUM_TOP;
      end
      if (total < SUM_BOTTOM) begin
         total = SUM_BOTTOM;
      end
      integrator = total[SUM_W-1:0];

      span = regs.bit_length;
      if (span == 0) begin
         span = 1;
      end
      if (span > MAX_BIT_LENGTH) begin
         span = MAX_BIT_LENGTH;
      end
      count = samples_in_bit + 1;

      if (count >= span || last) begin
         d.bit_out = (integrator > $signed(regs.decision_level));
         d.bit_sum = integrator;
         expected_decisions = {expected_decisions, d};
         integrator     = '0;
         samples_in_bit = 0;
         if (last) begin
            lo_phase = '0;
         end
      end else begin
         samples_in_bit = count;
      end
   endtask

   always @(posedge clock) begin : watch
      decision_type want;
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            n_samples++;
            mix_and_integrate(req_sample, req_stream_end);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decisions.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected decision bit %0b sum %0d", $time,
                           rsp_bit_out, rsp_bit_sum);
               end
            end else begin
               want = expected_decisions.pop_front();
               n_checked++;
               if (rsp_bit_out !== want.bit_out || rsp_bit_sum !== want.bit_sum) begin
                  errors++;
                  if (errors <= 10) begin
                     $display({"%0t: decision mismatch: expected bit %0b sum %0d,",
                               " got bit %0b sum %0d"},
                              $time, want.bit_out, want.bit_sum, rsp_bit_out, rsp_bit_sum);
                  end
               end
            end
         end
      end
      mismatch_count    <= errors;
      pending_decisions <= expected_decisions.size();
      samples_seen      <= n_samples;
      decisions_checked <= n_checked;
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb: testbench top of the coherent ASK/PSK demodulator
// Drives register writes, and samples with random idle gaps, stalls the
// decision port at random and once for a long stretch, and leaves all
// prediction and comparison to the decision checker beside the block.
// ============================================================================
module tb;
   import apcd_pkg::*;

   // Settling time after the last expected decision; it covers a request that
   // closes no bit but is still in the pipeline.
   localparam int LATENCY_SETTLE = 6;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 55;
   localparam int CEILING_ITEMS  = 120;
   localparam int END_ODDS       = 25;

   // An index outside the register map; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 4'd15;

   localparam logic signed [SUM_W-1:0] LEVEL_MIN = 32'sh8000_0000;
   localparam logic signed [SUM_W-1:0] LEVEL_MAX = 32'sh7FFF_FFFF;
   localparam logic [LEN_W-1:0]        LEN_CEILING = '1;
   localparam logic [PHASE_W-1:0]      QUARTER_TURN = 32'h4000_0000;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample     = '0;
   logic                       req_stream_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic                       rsp_bit_out;
   logic signed [SUM_W-1:0]    rsp_bit_sum;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index      = '0;
   logic [CSR_DAT_W-1:0]       csr_data       = '0;

   int mismatch_count;
   int pending_decisions;
   int samples_seen;
   int decisions_checked;

   // Shared between the stimulus and the receiver process, but for settings_loaded.
   bit idling_on       = 1'b0;
   int hold_off_cycles = 0;
   int settings_loaded = 0;

   ask_psk_coherent_demodulator_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bit_out    (rsp_bit_out),
      .rsp_bit_sum    (rsp_bit_sum),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   apcd_decision_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_stream_end    (req_stream_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bit_out       (rsp_bit_out),
      .rsp_bit_sum       (rsp_bit_sum),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .pending_decisions (pending_decisions),
      .samples_seen      (samples_seen),
      .decisions_checked (decisions_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Picks an idle gap; about one in five comes from the long range.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Full-scale and near-zero samples show up often enough to exercise the
   // truncation of the product at both ends; the rest is uniform noise.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offers one request and returns at the edge where it is accepted. Valid
   // is left high so that a following request can go out back to back.
   task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic last);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= s;
      req_stream_end <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic send_random(int n);
      for (int i = 0; i < n; i++) begin
         send_item(pick_sample(), $urandom_range(1, END_ODDS) == 1);
      end
   endtask

   // Drops valid, waits for every expected decision to come back and then
   // lets the pipeline run dry before the registers may be touched.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_decisions != 0);
      repeat (LATENCY_SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   // Writes the whole register set; only called while the block is idle.
   task automatic load_settings(logic psk, logic [LEN_W-1:0] len,
                                logic [PHASE_W-1:0] step,
                                logic signed [SUM_W-1:0] level, bit spare);
      write_reg(CSR_MODE_PSK, {31'd0, psk});
      write_reg(CSR_BIT_LENGTH, {21'd0, len});
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_DECISION_LEVEL, level);
      if (spare) begin
         write_reg(CSR_SPARE_INDEX, $urandom);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Receiver: ready most of the time, with random stalls while idling is
   // on, and one long hold-off on request from the stimulus so that the
   // block backs up all the way to its request port.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus and verdict.
   initial begin
      logic                    psk;
      logic [LEN_W-1:0]        len;
      logic [PHASE_W-1:0]      step;
      logic signed [SUM_W-1:0] level;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset values: a 288-sample bit period never completes here, so only
      // the stream end sample closes the partial bit.
      for (int i = 0; i < 3; i++) begin
         send_item(pick_sample(), 1'b0);
      end
      send_item(pick_sample(), 1'b1);
      settle();

      // Quarter-turn carrier steps through zero, plus full scale, zero and
      // minus full scale. The first bit lands exactly on the decision level
      // and must decide 0; the second is one above it and must decide 1.
      // The stream end then closes a one-sample bit and rewinds the phase.
      load_settings(1'b0, 11'd2, QUARTER_TURN, 32'sd32766, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh0000, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sd12345, 1'b1);
      send_item(-16'sd1, 1'b0);
      send_item(16'sd1, 1'b1);
      settle();

      // PSK with a zero bit length, which behaves as one sample per bit, the
      // largest phase step and the lowest possible decision level.
      load_settings(1'b1, 11'd0, 32'hFFFF_FFFF, LEVEL_MIN, 1'b1);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh0000, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(16'sh5555, 1'b0);
      send_item(16'shAAAA, 1'b1);
      settle();

      // Shortening the bit period in the middle of a bit: three samples are
      // integrated under a length of five, then the length drops to two and
      // the very next sample has to close the bit.
      step = $urandom;
      load_settings(1'b0, 11'd5, step, LEVEL_MAX, 1'b0);
      send_random(0);
      for (int i = 0; i < 3; i++) begin
         send_item(pick_sample(), 1'b0);
      end
      settle();
      load_settings(1'b0, 11'd2, step, 32'sd0, 1'b0);
      for (int i = 0; i < 3; i++) begin
         send_item(pick_sample(), 1'b0);
      end
      settle();

      // A length beyond the maximum acts as the maximum, so a long partial
      // bit integrates without a decision until the stream end closes it.
      idling_on = 1'b1;
      load_settings(1'b1, LEN_CEILING, $urandom, 32'sd0, 1'b0);
      for (int i = 0; i < CEILING_ITEMS; i++) begin
         send_item(pick_sample(), i == CEILING_ITEMS - 1);
      end
      settle();

      // Backpressure: one decision per sample while the receiver holds off and
      // the sender keeps offering requests.
      idling_on = 1'b0;
      load_settings(1'($urandom_range(0, 1)), 11'd1, $urandom,
                    32'($urandom_range(0, 20000)) - 32'sd10000, 1'b0);
      hold_off_cycles = 300;
      send_random(60);
      settle();

      // Random register settings, mostly short bit periods so that decisions
      // come often, with some phases run flat out and others with idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idling_on = (p % 3 != 0);
         psk = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0:       len = 11'd0;
            1:       len = 11'd1;
            2:       len = 11'($urandom_range(40, 120));
            default: len = 11'($urandom_range(2, 24));
         endcase
         case ($urandom_range(0, 5))
            0:       step = '0;
            1:       step = '1;
            2:       step = PHASE_STEP_RST;
            default: step = $urandom;
         endcase
         case ($urandom_range(0, 7))
            0:       level = LEVEL_MIN;
            1:       level = LEVEL_MAX;
            default: level = 32'($urandom_range(0, 60000)) - 32'sd30000;
         endcase
         load_settings(psk, len, step, level, p == 4);
         send_random(PHASE_ITEMS);
         settle();
      end

      $display("Run covered %0d samples and %0d bit decisions over %0d register settings,",
               samples_seen, decisions_checked, settings_loaded);
      $display("with ASK and PSK, bit lengths 0 to 2047, stream ends and a long output stall.");
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Backstop in case the run hangs.
   initial begin
      #10_000_000;
      $display("timeout with %0d decisions still outstanding", pending_decisions);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
design/apcd_pkg.sv
design/apcd_csr.sv
design/apcd_dump.sv
design/ask_psk_coherent_demodulator_top.sv
tb/apcd_decision_checker.sv
tb/tb.sv
